FILE: hdl/gcd_pkg.sv
package gcd_pkg;

   localparam int LON_W = 25;
   localparam int LAT_W = 24;
   localparam int ANG_W = 26;
   localparam int OUT_W = 23;

   localparam int DEF_ANGLE_FRAC_BITS = 16;
   localparam int DEF_DIST_FRAC_BITS  = 8;

   localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
   localparam logic [31:0] PI_Q30        = 32'hC90F_DAA2;
   localparam logic [30:0] HALF_CIRC_Q16 = 31'd1311708728;
   localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;

   localparam int DIV_FULL = 360;
   localparam int DIV_HALF = 720;
   localparam int PH_BPS   = 4;

   localparam int SIN_ITERS = 8;
   localparam int SIN_LAT   = 2 + 2 * SIN_ITERS + 1;
   localparam int ASIN_BITS = 31;

   typedef struct packed {
      logic        neg;
      logic [30:0] r;
   } sin_arg_type;

endpackage

FILE: hdl/gcd_if.sv
interface gcd_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [gcd_pkg::LON_W-1:0] first_longitude;
   logic signed [gcd_pkg::LAT_W-1:0] first_latitude;
   logic signed [gcd_pkg::LON_W-1:0] second_longitude;
   logic signed [gcd_pkg::LAT_W-1:0] second_latitude;

   modport source (output valid, first_longitude, first_latitude, second_longitude,
                   second_latitude, input ready);
   modport sink (input valid, first_longitude, first_latitude, second_longitude,
                 second_latitude, output ready);
endinterface

interface gcd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [gcd_pkg::OUT_W-1:0] distance_km;

   modport source (output valid, distance_km, input ready);
   modport sink (input valid, distance_km, output ready);
endinterface

FILE: hdl/gcd_sin.sv
module gcd_sin (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] arg,
   output logic [31:0] sine
);
   import gcd_pkg::*;

   logic [62:0] px0;
   logic [61:0] px1;
   logic [30:0] x0_ff, x1_ff;
   logic [31:0] x2_ff;
   logic [31:0] va_ff  [SIN_ITERS];
   logic [30:0] xa_ff  [SIN_ITERS];
   logic [31:0] x2a_ff [SIN_ITERS];
   logic [30:0] tb_ff  [SIN_ITERS];
   logic [30:0] xb_ff  [SIN_ITERS];
   logic [31:0] x2b_ff [SIN_ITERS];
   logic [61:0] ps;
   logic [31:0] sine_ff;

   assign px0 = 63'(arg) * 63'(PI_Q30);
   assign px1 = 62'(x0_ff) * 62'(x0_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= px0[61:31];
         x1_ff <= x0_ff;
         x2_ff <= px1[61:30];
      end
   end

   // Horner steps of the series, highest term first
   for (genvar i = 0; i < SIN_ITERS; i++) begin : g_iter
      localparam int K  = 16 - 2 * i;
      localparam int D  = K * (K + 1);
      localparam int SH = 32 + $clog2(D);
      localparam longint unsigned MUL = ((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D);

      logic [30:0] x_src, t_src;
      logic [31:0] x2_src;
      logic [62:0] pv;
      logic [64:0] pm;
      logic [31:0] qd;

      if (i == 0) begin : g_first
         assign x_src  = x1_ff;
         assign x2_src = x2_ff;
         assign t_src  = Q30_ONE;
      end else begin : g_next
         assign x_src  = xb_ff[i-1];
         assign x2_src = x2b_ff[i-1];
         assign t_src  = tb_ff[i-1];
      end

      assign pv = 63'(x2_src) * 63'(t_src);
      assign pm = 65'(va_ff[i]) * 65'(MUL);
      assign qd = 32'(pm >> SH);

      always_ff @(posedge clock) begin
         if (en) begin
            va_ff[i]  <= pv[61:30];
            xa_ff[i]  <= x_src;
            x2a_ff[i] <= x2_src;
            tb_ff[i]  <= Q30_ONE - qd[30:0];
            xb_ff[i]  <= xa_ff[i];
            x2b_ff[i] <= x2a_ff[i];
         end
      end
   end

   assign ps = 62'(xb_ff[SIN_ITERS-1]) * 62'(tb_ff[SIN_ITERS-1]);

   always_ff @(posedge clock) begin
      if (en) begin
         sine_ff <= ps[61:30];
      end
   end

   assign sine = sine_ff;

endmodule

FILE: hdl/gcd_phase.sv
module gcd_phase #(
   parameter int          AFB    = gcd_pkg::DEF_ANGLE_FRAC_BITS,
   parameter int          DIV    = gcd_pkg::DIV_HALF,
   parameter logic [31:0] OFFSET = 32'd0
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [gcd_pkg::ANG_W-1:0]   angle,
   output gcd_pkg::sin_arg_type               arg
);
   import gcd_pkg::*;

   localparam int SH   = 32 - AFB;
   localparam int NBIT = ANG_W + SH;
   localparam int NSTG = (NBIT + PH_BPS - 1) / PH_BPS;
   localparam int DW   = NSTG * PH_BPS;
   localparam int RW   = $clog2(DIV);

   logic [ANG_W-1:0] mag_in;
   logic [DW-1:0]    dvd_ff;
   logic             sgn_ff;
   logic [RW-1:0]    rem_ff  [NSTG];
   logic [31:0]      quo_ff  [NSTG];
   logic [DW-1:0]    dvds_ff [NSTG];
   logic             sgns_ff [NSTG];
   logic [31:0]      p_in, p_ff;
   sin_arg_type      arg_in, arg_ff;

   assign mag_in = angle[ANG_W-1] ? ANG_W'(-angle) : ANG_W'(angle);

   always_ff @(posedge clock) begin
      if (en) begin
         dvd_ff <= DW'({mag_in, {SH{1'b0}}});
         sgn_ff <= angle[ANG_W-1];
      end
   end

   // Long division by the constant, a few dividend bits per stage
   for (genvar j = 0; j < NSTG; j++) begin : g_stg
      logic [RW-1:0] rem_src, rem_in;
      logic [31:0]   quo_src, quo_in;
      logic [DW-1:0] dvd_src;
      logic          sgn_src;

      if (j == 0) begin : g_first
         assign rem_src = '0;
         assign quo_src = '0;
         assign dvd_src = dvd_ff;
         assign sgn_src = sgn_ff;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign quo_src = quo_ff[j-1];
         assign dvd_src = dvds_ff[j-1];
         assign sgn_src = sgns_ff[j-1];
      end

      always_comb begin
         logic [RW:0] w;
         rem_in = rem_src;
         quo_in = quo_src;
         for (int b = 0; b < PH_BPS; b++) begin
            w = {rem_in, dvd_src[DW-1-j*PH_BPS-b]};
            if (w >= (RW+1)'(DIV)) begin
               w = w - (RW+1)'(DIV);
               quo_in = {quo_in[30:0], 1'b1};
            end else begin
               quo_in = {quo_in[30:0], 1'b0};
            end
            rem_in = w[RW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            quo_ff[j]  <= quo_in;
            dvds_ff[j] <= dvd_src;
            sgns_ff[j] <= sgn_src;
         end
      end
   end

   assign p_in = sgns_ff[NSTG-1] ? OFFSET - quo_ff[NSTG-1] : OFFSET + quo_ff[NSTG-1];

   // Fold the phase into the first quadrant; keep the sign of the half turn
   always_comb begin
      arg_in.neg = p_ff[31];
      if (p_ff[30]) begin
         arg_in.r = Q30_ONE - {1'b0, p_ff[29:0]};
      end else begin
         arg_in.r = {1'b0, p_ff[29:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= p_in;
         arg_ff <= arg_in;
      end
   end

   assign arg = arg_ff;

endmodule

FILE: hdl/gcd_asin_cell.sv
module gcd_asin_cell #(
   parameter int BIT = 30
) (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] prev_q,
   input  logic [30:0] prev_a,
   output logic [30:0] next_q,
   output logic [30:0] next_a
);
   import gcd_pkg::*;

   typedef struct packed {
      logic [30:0] q;
      logic [30:0] a;
      logic [30:0] cand;
      logic        ok;
   } cell_ctx_type;

   cell_ctx_type ctx_in;
   cell_ctx_type ctx_ff [SIN_LAT];
   cell_ctx_type ctx2_ff;
   logic [31:0]  s;
   logic [63:0]  sq;
   logic [33:0]  s2_ff;
   logic [30:0]  q_ff, a_ff;

   always_comb begin
      ctx_in.q    = prev_q;
      ctx_in.a    = prev_a;
      ctx_in.cand = prev_q | (31'd1 << BIT);
      ctx_in.ok   = ctx_in.cand <= Q30_ONE;
   end

   gcd_sin u_sin (
      .clock (clock),
      .en    (en),
      .arg   (ctx_in.cand),
      .sine  (s)
   );

   assign sq = 64'(s) * 64'(s);

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff[0] <= ctx_in;
         for (int i = 1; i < SIN_LAT; i++) begin
            ctx_ff[i] <= ctx_ff[i-1];
         end
         s2_ff   <= sq[63:30];
         ctx2_ff <= ctx_ff[SIN_LAT-1];
         // keep the trial bit when its sine squared stays within a
         if (ctx2_ff.ok && (s2_ff <= 34'(ctx2_ff.a))) begin
            q_ff <= ctx2_ff.cand;
         end else begin
            q_ff <= ctx2_ff.q;
         end
         a_ff <= ctx2_ff.a;
      end
   end

   assign next_q = q_ff;
   assign next_a = a_ff;

endmodule

FILE: hdl/great_circle_distance.sv
// Throughput: one beat per cycle unless a result waits on rsp_bus.ready;
// every stage, down to the 31 arcsine cells with a 19-stage sine pipeline each,
// is fully pipelined and moves on a single advance.
// Reset: synchronous, clears the stage valid flags only; data registers are not reset.
module great_circle_distance #(
   parameter int ANGLE_FRAC_BITS = gcd_pkg::DEF_ANGLE_FRAC_BITS,
   parameter int DIST_FRAC_BITS  = gcd_pkg::DEF_DIST_FRAC_BITS
) (
   input logic       clock,
   input logic       reset,
   gcd_req_if.sink   req_bus,
   gcd_rsp_if.source rsp_bus
);
   import gcd_pkg::*;

   localparam int PH_LAT = 3 + (ANG_W + 32 - ANGLE_FRAC_BITS + PH_BPS - 1) / PH_BPS;
   localparam int A_IDX  = 1 + PH_LAT + SIN_LAT + 2;
   localparam int LAT    = A_IDX + 1 + ASIN_BITS * (SIN_LAT + 2) + 1;
   localparam int RSH    = 46 - DIST_FRAC_BITS;

   logic                    adv;
   logic [LAT-1:0]          vld_ff;
   logic signed [ANG_W-1:0] ang_ff [4];
   sin_arg_type             arg [4];
   logic [31:0]             sm [4];
   logic [3:0]              negd_ff [SIN_LAT];
   logic [63:0]             p_lat, p_lon, p_cc;
   logic [33:0]             sl2_ff, so2_ff, ccm_ff, sl2b_ff;
   logic                    cneg_ff, tneg_ff;
   logic [67:0]             p_t2;
   logic [37:0]             t2_ff;
   logic signed [39:0]      sum_a;
   logic [30:0]             a_in, a_ff;
   logic [30:0]             cq [ASIN_BITS+1];
   logic [30:0]             ca [ASIN_BITS+1];
   logic [61:0]             p_d;
   logic [62:0]             sum_d, dw;
   logic [OUT_W-1:0]        dist_in, dist_ff;

   assign adv           = !vld_ff[LAT-1] || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_bus.valid};
      end
   end

   // Lanes: half latitude difference, half longitude difference, both latitudes
   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff[0] <= ANG_W'(req_bus.second_latitude) - ANG_W'(req_bus.first_latitude);
         ang_ff[1] <= ANG_W'(req_bus.second_longitude) - ANG_W'(req_bus.first_longitude);
         ang_ff[2] <= ANG_W'(req_bus.first_latitude);
         ang_ff[3] <= ANG_W'(req_bus.second_latitude);
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_lane
      gcd_phase #(
         .AFB    (ANGLE_FRAC_BITS),
         .DIV    ((i < 2) ? DIV_HALF : DIV_FULL),
         .OFFSET ((i < 2) ? 32'd0 : QUARTER_TURN)
      ) u_phase (
         .clock (clock),
         .en    (adv),
         .angle (ang_ff[i]),
         .arg   (arg[i])
      );

      gcd_sin u_sin (
         .clock (clock),
         .en    (adv),
         .arg   (arg[i].r),
         .sine  (sm[i])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         negd_ff[0] <= {arg[3].neg, arg[2].neg, arg[1].neg, arg[0].neg};
         for (int i = 1; i < SIN_LAT; i++) begin
            negd_ff[i] <= negd_ff[i-1];
         end
      end
   end

   assign p_lat = 64'(sm[0]) * 64'(sm[0]);
   assign p_lon = 64'(sm[1]) * 64'(sm[1]);
   assign p_cc  = 64'(sm[2]) * 64'(sm[3]);
   assign p_t2  = 68'(so2_ff) * 68'(ccm_ff);
   assign sum_a = tneg_ff ? 40'(sl2b_ff) - 40'(t2_ff) : 40'(sl2b_ff) + 40'(t2_ff);

   always_comb begin
      if (sum_a < 0) begin
         a_in = '0;
      end else if (sum_a > 40'(Q30_ONE)) begin
         a_in = Q30_ONE;
      end else begin
         a_in = sum_a[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sl2_ff  <= p_lat[63:30];
         so2_ff  <= p_lon[63:30];
         ccm_ff  <= p_cc[63:30];
         cneg_ff <= negd_ff[SIN_LAT-1][2] ^ negd_ff[SIN_LAT-1][3];
         sl2b_ff <= sl2_ff;
         t2_ff   <= p_t2[67:30];
         tneg_ff <= cneg_ff;
         a_ff    <= a_in;
      end
   end

   assign cq[0] = '0;
   assign ca[0] = a_ff;

   for (genvar k = 0; k < ASIN_BITS; k++) begin : g_cell
      gcd_asin_cell #(
         .BIT (ASIN_BITS - 1 - k)
      ) u_cell (
         .clock  (clock),
         .en     (adv),
         .prev_q (cq[k]),
         .prev_a (ca[k]),
         .next_q (cq[k+1]),
         .next_a (ca[k+1])
      );
   end

   assign p_d   = 62'(cq[ASIN_BITS]) * 62'(HALF_CIRC_Q16);
   assign sum_d = 63'(p_d) + (63'd1 << (RSH - 1));
   assign dw    = sum_d >> RSH;
   assign dist_in = (|dw[62:OUT_W]) ? {OUT_W{1'b1}} : dw[OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_ff <= dist_in;
      end
   end

   assign rsp_bus.valid       = vld_ff[LAT-1];
   assign rsp_bus.distance_km = dist_ff;

   a_reset_clears_out : assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> vld_ff[0])
      else $error("accepted beat missing from first stage");

   a_sum_clamped : assert property (@(posedge clock) disable iff (reset)
      vld_ff[A_IDX] |-> (a_ff <= Q30_ONE))
      else $error("haversine term above one");

   a_first_cell : assert property (@(posedge clock) disable iff (reset)
      vld_ff[A_IDX + SIN_LAT + 2] |-> (cq[1] == '0 || cq[1] == Q30_ONE))
      else $error("first arcsine cell gave an impossible value");

endmodule
